/* rtl/core/kli_pkg.sv */
// ----------------------------------------------------------------------------
// kli_pkg
// Shared widths, codes and beat types for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int TIME_W         = 48;
    localparam int VAL_W          = 32;
    localparam int MAG_W          = VAL_W + 1;
    localparam int MAX_FRAMES_DEF = 16;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic [TIME_W-1:0]       time_ns;
        logic signed [VAL_W-1:0] frame_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
    } div_rsp_t;

endpackage

/* rtl/core/kli_table.sv */
// ----------------------------------------------------------------------------
// kli_table
// Keyframe store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kli_table #(
    parameter int DEPTH = kli_pkg::MAX_FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [kli_pkg::TIME_W-1:0]      wtime,
    input  logic [kli_pkg::VAL_W-1:0]       wvalue,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [kli_pkg::TIME_W-1:0]      rtime,
    output logic [kli_pkg::VAL_W-1:0]       rvalue
);

    logic [kli_pkg::TIME_W-1:0] time_mem [DEPTH];
    logic [kli_pkg::VAL_W-1:0]  value_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            time_mem[waddr]  <= wtime;
            value_mem[waddr] <= wvalue;
        end
        rtime  <= time_mem[raddr];
        rvalue <= value_mem[raddr];
    end

endmodule

/* rtl/core/kli_divider.sv */
// ----------------------------------------------------------------------------
// kli_divider
// Serial floor(mag * num / den), num < den: for each magnitude bit,
// a doubling step then a conditional add step, each with one reduce.
// ----------------------------------------------------------------------------
module kli_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  kli_pkg::div_req_t  req,
    output kli_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(kli_pkg::MAG_W);

    logic                        busy_reg, busy_next;
    logic                        phase_reg, phase_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [kli_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [kli_pkg::MAG_W-1:0]   quot_reg, quot_next;
    logic [kli_pkg::TIME_W-1:0]  rem_reg, rem_next;
    logic [kli_pkg::TIME_W-1:0]  num_reg, num_next;
    logic [kli_pkg::TIME_W-1:0]  den_reg, den_next;
    logic [kli_pkg::TIME_W:0]    sum;
    logic [kli_pkg::TIME_W:0]    den_ext;

    assign den_ext = {1'b0, den_reg};

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        sum        = '0;
        if (req.start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CNT_W'(kli_pkg::MAG_W - 1);
            mag_next   = req.mag;
            quot_next  = '0;
            rem_next   = '0;
            num_next   = req.num;
            den_next   = req.den;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                sum = {rem_reg, 1'b0};
                if (sum >= den_ext) begin
                    rem_next  = kli_pkg::TIME_W'(sum - den_ext);
                    quot_next = {quot_reg[kli_pkg::MAG_W-2:0], 1'b1};
                end else begin
                    rem_next  = sum[kli_pkg::TIME_W-1:0];
                    quot_next = {quot_reg[kli_pkg::MAG_W-2:0], 1'b0};
                end
                phase_next = 1'b1;
            end else begin
                if (mag_reg[kli_pkg::MAG_W-1]) begin
                    sum = {1'b0, rem_reg} + {1'b0, num_reg};
                    if (sum >= den_ext) begin
                        rem_next  = kli_pkg::TIME_W'(sum - den_ext);
                        quot_next = quot_reg + kli_pkg::MAG_W'(1);
                    end else begin
                        rem_next = sum[kli_pkg::TIME_W-1:0];
                    end
                end
                mag_next   = {mag_reg[kli_pkg::MAG_W-2:0], 1'b0};
                phase_next = 1'b0;
                if (cnt_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        mag_reg  <= mag_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* rtl/core/keyframe_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Keyframe table with clear, append and piecewise linear query.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per command (clear, append keyframe, query time).
//   m_ channel: exactly one result beat per command, in command order.
//   cfg_ channel: start_from_origin bit, always ready; write it while idle.
//   s_ready is high only while the sequencer is idle; one command at a time.
// Flow (accept to m_valid):
//   clear / append / empty query: result set at accept, then output.
//   query holding a table value: table scan, then output.
//   interpolating query: table scan, then serial divide; the scan reads the
//   table one entry at a time through its single registered read port, and the
//   serial divider handles the 33-bit value delta one bit at a time.
// Reset empties the table and clears start_from_origin; table contents stay
//   undefined, no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
//   command is accepted meanwhile and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
    parameter int MAX_FRAMES = kli_pkg::MAX_FRAMES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kli_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output kli_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TW    = kli_pkg::TIME_W;
    localparam int VW    = kli_pkg::VAL_W;
    localparam int MW    = kli_pkg::MAG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_MAG  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               origin_reg, origin_next;
    logic               m_valid_reg, m_valid_next;
    kli_pkg::out_item_t m_item_reg, m_item_next;
    logic [TW-1:0]      last_time_reg, last_time_next;
    logic [TW-1:0]      q_time_reg, q_time_next;
    logic [TW-1:0]      prev_time_reg, prev_time_next;
    logic [VW-1:0]      prev_value_reg, prev_value_next;
    logic [TW-1:0]      t1_reg, t1_next;
    logic [VW-1:0]      v1_reg, v1_next;
    logic [TW-1:0]      num_reg, num_next;
    logic [TW-1:0]      den_reg, den_next;
    logic [MW-1:0]      diff_reg, diff_next;
    logic [VW-1:0]      res_value_reg, res_value_next;
    logic [1:0]         res_status_reg, res_status_next;

    logic               tbl_we;
    logic [TW-1:0]      rd_time;
    logic [VW-1:0]      rd_value;
    logic               s_beat;
    kli_pkg::div_req_t  div_req;
    kli_pkg::div_rsp_t  div_rsp;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    kli_table #(
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .aclk   (aclk),
        .we     (tbl_we),
        .waddr  (count_reg[IDX_W-1:0]),
        .wtime  (s_item.time_ns),
        .wvalue (s_item.frame_value),
        .raddr  (idx_reg[IDX_W-1:0]),
        .rtime  (rd_time),
        .rvalue (rd_value)
    );

    assign div_req.start = (state_reg == S_MAG);
    assign div_req.mag   = diff_reg[MW-1] ? MW'(-diff_reg) : diff_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    kli_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        origin_next     = origin_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        last_time_next  = last_time_reg;
        q_time_next     = q_time_reg;
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        t1_next         = t1_reg;
        v1_next         = v1_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        diff_next       = diff_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        tbl_we          = 1'b0;

        if (cfg_valid) begin
            origin_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    res_value_next  = '0;
                    res_status_next = kli_pkg::STAT_OK;
                    state_next      = S_OUT;
                    case (s_item.action)
                        kli_pkg::ACT_CLEAR: begin
                            count_next = '0;
                        end
                        kli_pkg::ACT_APPEND: begin
                            if (count_reg == CNT_W'(MAX_FRAMES)) begin
                                res_status_next = kli_pkg::STAT_FULL;
                            end else if (count_reg != '0 &&
                                         s_item.time_ns <= last_time_reg) begin
                                res_status_next = kli_pkg::STAT_ORDER;
                            end else begin
                                tbl_we          = 1'b1;
                                last_time_next  = s_item.time_ns;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        kli_pkg::ACT_QUERY: begin
                            if (count_reg == '0) begin
                                res_status_next = kli_pkg::STAT_EMPTY;
                            end else begin
                                q_time_next     = s_item.time_ns;
                                idx_next        = '0;
                                prev_time_next  = '0;
                                prev_value_next = '0;
                                state_next      = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (rd_time > q_time_reg) begin
                    t1_next = rd_time;
                    v1_next = rd_value;
                    if (idx_reg == '0 && !origin_reg) begin
                        res_value_next = rd_value;
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_DIFF;
                    end
                end else begin
                    prev_time_next  = rd_time;
                    prev_value_next = rd_value;
                    idx_next        = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == count_reg) begin
                        // past the last keyframe: hold its value
                        res_value_next = rd_value;
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_DIFF: begin
                num_next   = q_time_reg - prev_time_reg;
                den_next   = t1_reg - prev_time_reg;
                diff_next  = {v1_reg[VW-1], v1_reg} - {prev_value_reg[VW-1], prev_value_reg};
                state_next = S_MAG;
            end
            S_MAG: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (diff_reg[MW-1]) begin
                        res_value_next = prev_value_reg - div_rsp.quot[VW-1:0];
                    end else begin
                        res_value_next = prev_value_reg + div_rsp.quot[VW-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_item_next.result_value = res_value_reg;
                    m_item_next.status       = res_status_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            origin_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            origin_reg  <= origin_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg     <= m_item_next;
        last_time_reg  <= last_time_next;
        q_time_reg     <= q_time_next;
        prev_time_reg  <= prev_time_next;
        prev_value_reg <= prev_value_next;
        t1_reg         <= t1_next;
        v1_reg         <= v1_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        diff_reg       <= diff_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above table depth");

    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_CMP) |-> idx_reg < count_reg)
        else $error("scan index past valid entries");

    a_div_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_item.action == kli_pkg::ACT_CLEAR) |=> count_reg == '0)
        else $error("clear beat left entries in table");
`endif

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyframe_linear_interpolator: directed table and
// origin cases, then random keyframe tables with query bursts, random stalls
// on the command and result channels, every result beat compared against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_FRAMES  = kli_pkg::MAX_FRAMES_DEF;
    localparam int          TIME_W      = kli_pkg::TIME_W;
    localparam int          VAL_W       = kli_pkg::VAL_W;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [47:0] TIME_MAX    = '1;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam int          STALL_LIMIT = 3000;
    localparam int          TAIL_CYCLES = 120;

    typedef logic [TIME_W-1:0] time_tbl_t [MAX_FRAMES];

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    kli_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready = 1'b0;
    kli_pkg::out_item_t m_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // predictor state
    logic [TIME_W-1:0]       kf_time [MAX_FRAMES];
    logic signed [VAL_W-1:0] kf_val  [MAX_FRAMES];
    int unsigned             kf_count    = 0;
    logic                    origin_mode = 1'b0;

    kli_pkg::out_item_t awaited_results[$];
    logic        no_idle         = 1'b0;
    int unsigned sink_hold       = 0;
    int unsigned idle_cycles     = 0;
    int unsigned errors          = 0;
    int unsigned results_checked = 0;
    int unsigned cmds_sent       = 0;
    int unsigned query_cnt       = 0;
    int unsigned interp_cnt      = 0;
    int unsigned cfg_writes      = 0;

    keyframe_linear_interpolator #(
        .MAX_FRAMES(MAX_FRAMES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] value_at(logic [TIME_W-1:0] t);
        int unsigned        idx;
        logic signed [33:0] v0, v1, delta, res;
        logic [33:0]        mag, qs;
        logic [TIME_W-1:0]  t0, t1;
        logic [127:0]       q;
        idx = 0;
        while (idx < kf_count && kf_time[idx] <= t)
            idx++;
        if (idx >= kf_count)
            return kf_val[kf_count-1];
        if (idx == 0 && !origin_mode)
            return kf_val[0];
        if (idx == 0) begin
            v0 = '0;
            t0 = '0;
        end else begin
            v0 = kf_val[idx-1];
            t0 = kf_time[idx-1];
        end
        v1 = kf_val[idx];
        t1 = kf_time[idx];
        delta = v1 - v0;
        mag = delta[33] ? -delta : delta;
        // exact product then truncating divide; t - t0 < t1 - t0 so q <= mag
        q = (128'(mag) * 128'(t - t0)) / 128'(t1 - t0);
        qs = q[33:0];
        res = delta[33] ? v0 - $signed(qs) : v0 + $signed(qs);
        interp_cnt++;
        return res[VAL_W-1:0];
    endfunction

    function automatic kli_pkg::out_item_t predict_command(kli_pkg::in_item_t c);
        kli_pkg::out_item_t r;
        r.result_value = '0;
        r.status       = kli_pkg::STAT_OK;
        case (c.action)
            kli_pkg::ACT_CLEAR: kf_count = 0;
            kli_pkg::ACT_APPEND: begin
                if (kf_count >= MAX_FRAMES) begin
                    r.status = kli_pkg::STAT_FULL;
                end else if (kf_count > 0 && c.time_ns <= kf_time[kf_count-1]) begin
                    r.status = kli_pkg::STAT_ORDER;
                end else begin
                    kf_time[kf_count] = c.time_ns;
                    kf_val[kf_count]  = c.frame_value;
                    kf_count++;
                end
            end
            kli_pkg::ACT_QUERY: begin
                query_cnt++;
                if (kf_count == 0)
                    r.status = kli_pkg::STAT_EMPTY;
                else
                    r.result_value = value_at(c.time_ns);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time(int unsigned bits);
        logic [63:0]       r;
        logic [TIME_W-1:0] mask;
        r = {$urandom, $urandom};
        mask = (bits >= TIME_W) ? '1 : ((48'd1 << bits) - 48'd1);
        return r[TIME_W-1:0] & mask;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] query_time(time_tbl_t kt, int unsigned n);
        int unsigned       k;
        logic [TIME_W-1:0] lo, span;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return kt[k];
            1: return $urandom_range(0, 1) ? kt[k] + 48'd1 : kt[k] - 48'd1;
            2: begin
                lo   = (k == 0) ? '0 : kt[k-1];
                span = kt[k] - lo;
                return (span == 0) ? lo : lo + rand_time(TIME_W) % span;
            end
            3: begin
                if (kt[0] == TIME_MAX)
                    return rand_time(TIME_W);
                return rand_time(TIME_W) % (kt[0] + 48'd1);
            end
            4: return kt[n-1] + rand_time($urandom_range(0, TIME_W));
            default: return rand_time(TIME_W);
        endcase
    endfunction

    function automatic kli_pkg::in_item_t cmd_of(logic [1:0] a, logic [TIME_W-1:0] t,
                                                 logic signed [VAL_W-1:0] v);
        kli_pkg::in_item_t c;
        c.action      = a;
        c.time_ns     = t;
        c.frame_value = v;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_cmd(kli_pkg::in_item_t cmd);
        int unsigned        gap;
        kli_pkg::out_item_t res;
        gap = (no_idle || $urandom_range(0, 1)) ? 0 : pick_stall();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= cmd;
        do @(posedge aclk); while (!s_ready);
        res = predict_command(cmd);
        awaited_results.push_back(res);
        cmds_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    // register writes only with the block idle
    task automatic set_origin(logic v);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        origin_mode = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (sink_hold != 0)
            sink_hold--;
        else if (!no_idle && $urandom_range(0, 3) == 0)
            sink_hold = pick_stall();
        m_ready <= (sink_hold == 0);
    end

    always @(posedge aclk) begin : check_results
        kli_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result beat: result_value %0d status %0d",
                       m_item.result_value, m_item.status);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (want.result_value !== m_item.result_value) begin
                    $error("result_value: expected %0d, actual %0d",
                           want.result_value, m_item.result_value);
                    errors++;
                end
                if (want.status !== m_item.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_item.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, TIME_MAX, VAL_MAX));
        send_cmd(cmd_of(ACT_UNUSED, TIME_MAX, VAL_MIN));
    endtask

    task automatic test_hold_and_origin();
        send_cmd(cmd_of(kli_pkg::ACT_APPEND, 48'd1000, VAL_MAX));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd999, '0));
        // exact keyframe time is not later: falls through to last value
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd1000, '0));
        set_origin(1'b1);
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd500, '0));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd0, '0));
        set_origin(1'b0);
    endtask

    task automatic test_full_table();
        int unsigned       k;
        logic [TIME_W-1:0] t;
        for (k = 1; k < MAX_FRAMES; k++) begin
            t = (k == MAX_FRAMES - 1) ? TIME_MAX : 48'd1000 + (48'(k) << 43);
            send_cmd(cmd_of(kli_pkg::ACT_APPEND, t, k[0] ? VAL_MIN : VAL_MAX));
            if (k == 5)
                send_cmd(cmd_of(kli_pkg::ACT_APPEND, t, VAL_MAX));
        end
        // equal to last time as well, but fullness wins
        send_cmd(cmd_of(kli_pkg::ACT_APPEND, TIME_MAX, VAL_MAX));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd1000 + (48'd1 << 42), '0));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, TIME_MAX - 48'd1, '0));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, TIME_MAX, '0));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd0, '0));
        send_cmd(cmd_of(kli_pkg::ACT_CLEAR, TIME_MAX, VAL_MIN));
        send_cmd(cmd_of(kli_pkg::ACT_QUERY, 48'd1000, '0));
    endtask

    task automatic test_random_tables(int unsigned target);
        time_tbl_t   kt;
        int unsigned n, k, gap_bits;
        while (cmds_sent < target) begin
            set_origin(1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(5, 20))
                    send_cmd(cmd_of(2'($urandom_range(0, 3)),
                                    rand_time($urandom_range(0, TIME_W)), rand_value()));
            end else begin
                send_cmd(cmd_of(kli_pkg::ACT_CLEAR, rand_time(TIME_W), rand_value()));
                n = $urandom_range(1, MAX_FRAMES);
                // gaps below 2^43 keep a full table under 2^47
                gap_bits = $urandom_range(0, 43);
                for (k = 0; k < n; k++) begin
                    kt[k] = (k == 0) ? rand_time(gap_bits)
                                     : kt[k-1] + 48'd1 + rand_time(gap_bits);
                    if (k == n - 1 && $urandom_range(0, 7) == 0)
                        kt[k] = TIME_MAX;
                    send_cmd(cmd_of(kli_pkg::ACT_APPEND, kt[k], rand_value()));
                end
                if (n == MAX_FRAMES && $urandom_range(0, 1))
                    send_cmd(cmd_of(kli_pkg::ACT_APPEND, rand_time(TIME_W), rand_value()));
                repeat ($urandom_range(4, 30)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_cmd(cmd_of(2'($urandom_range(0, 3)), rand_time(TIME_W),
                                        rand_value()));
                    else
                        send_cmd(cmd_of(kli_pkg::ACT_QUERY, query_time(kt, n),
                                        rand_value()));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_hold_and_origin();
        test_full_table();
        test_random_tables(1450);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d result beats for %0d commands: %0d queries, %0d interpolated.",
                 results_checked, cmds_sent, query_cnt, interp_cnt);
        $display("start_from_origin written %0d times, %0d mismatches.", cfg_writes, errors);
        if (errors == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
